// File: sv/lwfs_pkg.sv
// Shared types, register codes and helpers for the LCD window fill sequencer.
`timescale 1ns / 1ps
`default_nettype none
package lwfs_pkg;

  localparam int COORD_W = 9;
  localparam int COLOR_W = 16;
  localparam int COUNT_W = 17;
  localparam int INDEX_W = 8;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 48;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  typedef logic [COORD_W-1:0] coord_t;

  // Request kinds carried in tuser.
  localparam logic [2:0] REQ_PIXEL  = 3'd0;
  localparam logic [2:0] REQ_HLINE  = 3'd1;
  localparam logic [2:0] REQ_VLINE  = 3'd2;
  localparam logic [2:0] REQ_RECT   = 3'd3;
  localparam logic [2:0] REQ_ROTATE = 3'd4;

  // Controller register indexes.
  localparam logic [INDEX_W-1:0] REG_ENTRY_MODE = 8'h03;
  localparam logic [INDEX_W-1:0] REG_ADDR_X     = 8'h20;
  localparam logic [INDEX_W-1:0] REG_ADDR_Y     = 8'h21;
  localparam logic [INDEX_W-1:0] REG_GRAM       = 8'h22;
  localparam logic [INDEX_W-1:0] REG_WIN_XS     = 8'h50;
  localparam logic [INDEX_W-1:0] REG_WIN_XE     = 8'h51;
  localparam logic [INDEX_W-1:0] REG_WIN_YS     = 8'h52;
  localparam logic [INDEX_W-1:0] REG_WIN_YE     = 8'h53;

  localparam logic [2:0] STEP_LAST = 3'd6;

  // One queued job: a mapped window plus what goes before or after it.
  typedef struct packed {
    logic               rot;
    coord_t             ax1;
    coord_t             ax2;
    coord_t             ay1;
    coord_t             ay2;
    coord_t             cx;
    coord_t             cy;
    logic [COLOR_W-1:0] value;
    logic [COUNT_W-1:0] count;
  } cmd_t;

  function automatic logic [COLOR_W-1:0] entry_mode(input logic [1:0] rotation);
    logic [COLOR_W-1:0] m;
    case (rotation)
      2'd0:    m = 16'h1030;
      2'd1:    m = 16'h1028;
      2'd2:    m = 16'h1000;
      2'd3:    m = 16'h1018;
      default: m = 16'h1030;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

// File: sv/lwfs_front.sv
// Front end: accept requests, drop empty ones, clip, rotate and size the fill.
`timescale 1ns / 1ps
`default_nettype none
module lwfs_front #(
  parameter int PANEL_WIDTH  = 240,
  parameter int PANEL_HEIGHT = 320
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   cfg_we,
  input  wire  [1:0]                            cfg_rotation,
  input  wire                                   s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire  [lwfs_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  input  wire  [2:0]                            s_axis_tuser,
  output logic                                  push_valid,
  input  wire                                   push_ready,
  output lwfs_pkg::cmd_t                        push_data
);

  typedef struct packed {
    logic                         rot;
    lwfs_pkg::coord_t             x1;
    lwfs_pkg::coord_t             y1;
    lwfs_pkg::coord_t             x2;
    lwfs_pkg::coord_t             y2;
    lwfs_pkg::coord_t             w;
    lwfs_pkg::coord_t             h;
    logic [lwfs_pkg::COLOR_W-1:0] value;
  } clip_t;

  localparam lwfs_pkg::coord_t PW    = lwfs_pkg::coord_t'(PANEL_WIDTH);
  localparam lwfs_pkg::coord_t PH    = lwfs_pkg::coord_t'(PANEL_HEIGHT);
  localparam lwfs_pkg::coord_t PW_M1 = lwfs_pkg::coord_t'(PANEL_WIDTH - 1);
  localparam lwfs_pkg::coord_t PH_M1 = lwfs_pkg::coord_t'(PANEL_HEIGHT - 1);
  localparam lwfs_pkg::coord_t ONE   = lwfs_pkg::coord_t'(1);

  logic [1:0] rotation;
  logic       s1_valid;
  clip_t      s1;

  logic             [2:0] req;
  lwfs_pkg::coord_t       x, y, w_in, h_in, lw, lh;
  lwfs_pkg::coord_t       w_used, h_used, room_w, room_h, w_clip, h_clip;
  logic                   is_rot, keep, s1_ready;
  clip_t                  clip;

  assign req  = s_axis_tuser;
  assign x    = s_axis_tdata[8:0];
  assign y    = s_axis_tdata[17:9];
  assign w_in = s_axis_tdata[26:18];
  assign h_in = s_axis_tdata[35:27];

  always_comb begin
    lw     = rotation[0] ? PH : PW;
    lh     = rotation[0] ? PW : PH;
    is_rot = (req == lwfs_pkg::REQ_ROTATE);
    w_used = (req == lwfs_pkg::REQ_HLINE || req == lwfs_pkg::REQ_RECT) ? w_in : ONE;
    h_used = (req == lwfs_pkg::REQ_VLINE || req == lwfs_pkg::REQ_RECT) ? h_in : ONE;
    room_w = lw - x;
    room_h = lh - y;
    w_clip = (w_used > room_w) ? room_w : w_used;
    h_clip = (h_used > room_h) ? room_h : h_used;
    keep   = is_rot || (req <= lwfs_pkg::REQ_RECT && x < lw && y < lh &&
                        w_used != '0 && h_used != '0);
    if (is_rot) begin
      clip.rot   = 1'b1;
      clip.x1    = '0;
      clip.y1    = '0;
      clip.x2    = lw - ONE;
      clip.y2    = lh - ONE;
      clip.w     = ONE;
      clip.h     = ONE;
      clip.value = lwfs_pkg::entry_mode(rotation);
    end else begin
      clip.rot   = 1'b0;
      clip.x1    = x;
      clip.y1    = y;
      clip.x2    = x + w_clip - ONE;
      clip.y2    = y + h_clip - ONE;
      clip.w     = w_clip;
      clip.h     = h_clip;
      clip.value = s_axis_tdata[51:36];
    end
  end

  assign s1_ready      = !s1_valid || push_ready;
  assign s_axis_tready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation <= 2'd0;
      s1_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        rotation <= cfg_rotation;
      end
      if (s1_ready) begin
        s1_valid <= s_axis_tvalid && keep;
      end
    end
    if (s1_ready && s_axis_tvalid) begin
      s1 <= clip;
    end
  end

  // Rotate into panel coordinates and size the GRAM fill.
  logic [2*lwfs_pkg::COORD_W-1:0] prod;

  always_comb begin
    prod            = {{lwfs_pkg::COORD_W{1'b0}}, s1.w} * {{lwfs_pkg::COORD_W{1'b0}}, s1.h};
    push_data.rot   = s1.rot;
    push_data.value = s1.value;
    push_data.count = prod[2*lwfs_pkg::COORD_W-1] ? '1 : prod[lwfs_pkg::COUNT_W-1:0];
    case (rotation)
      2'd1: begin
        push_data.ax1 = PW_M1 - s1.y2;
        push_data.ax2 = PW_M1 - s1.y1;
        push_data.ay1 = s1.x1;
        push_data.ay2 = s1.x2;
        push_data.cx  = PW_M1 - s1.y1;
        push_data.cy  = s1.x1;
      end
      2'd2: begin
        push_data.ax1 = PW_M1 - s1.x2;
        push_data.ax2 = PW_M1 - s1.x1;
        push_data.ay1 = PH_M1 - s1.y2;
        push_data.ay2 = PH_M1 - s1.y1;
        push_data.cx  = PW_M1 - s1.x1;
        push_data.cy  = PH_M1 - s1.y1;
      end
      2'd3: begin
        push_data.ax1 = s1.y1;
        push_data.ax2 = s1.y2;
        push_data.ay1 = PH_M1 - s1.x2;
        push_data.ay2 = PH_M1 - s1.x1;
        push_data.cx  = s1.y1;
        push_data.cy  = PH_M1 - s1.x1;
      end
      default: begin
        push_data.ax1 = s1.x1;
        push_data.ax2 = s1.x2;
        push_data.ay1 = s1.y1;
        push_data.ay2 = s1.y2;
        push_data.cx  = s1.x1;
        push_data.cy  = s1.y1;
      end
    endcase
  end

  assign push_valid = s1_valid;

endmodule
`default_nettype wire

// File: sv/lwfs_queue.sv
// Show-ahead job queue between the front end and the write sequencer.
`timescale 1ns / 1ps
`default_nettype none
module lwfs_queue (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   push_valid,
  output logic                  push_ready,
  input  lwfs_pkg::cmd_t        push_data,
  output logic                  pop_valid,
  input  wire                   pop_ready,
  output lwfs_pkg::cmd_t        pop_data
);

  lwfs_pkg::cmd_t                mem [lwfs_pkg::QUEUE_DEPTH];
  logic [lwfs_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [lwfs_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [lwfs_pkg::QUEUE_AW:0]   fill;
  logic                          do_push, do_pop;

  assign push_ready = (fill != (lwfs_pkg::QUEUE_AW + 1)'(lwfs_pkg::QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

// File: sv/lwfs_back.sv
// Back end: walk each queued job through its register writes, one beat a cycle while the output is not stalled.
`timescale 1ns / 1ps
`default_nettype none
module lwfs_back (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                pop_valid,
  output logic                               pop_ready,
  input  lwfs_pkg::cmd_t                     pop_data,
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  output logic [lwfs_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                               m_axis_tlast
);

  logic [2:0]                   step;
  logic [2:0]                   wpos;
  logic                         out_free;
  logic [lwfs_pkg::INDEX_W-1:0] idx;
  logic [lwfs_pkg::COLOR_W-1:0] val;
  logic [lwfs_pkg::COUNT_W-1:0] cnt;
  logic [lwfs_pkg::INDEX_W-1:0] out_idx;
  logic [lwfs_pkg::COLOR_W-1:0] out_val;
  logic [lwfs_pkg::COUNT_W-1:0] out_cnt;

  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign pop_ready = out_free && (step == lwfs_pkg::STEP_LAST);

  // Rotation jobs lead with the entry mode, so their window runs one step late.
  always_comb begin
    wpos = pop_data.rot ? step - 3'd1 : step;
    cnt  = lwfs_pkg::COUNT_W'(1);
    if (pop_data.rot && step == 3'd0) begin
      idx = lwfs_pkg::REG_ENTRY_MODE;
      val = pop_data.value;
    end else if (!pop_data.rot && step == lwfs_pkg::STEP_LAST) begin
      idx = lwfs_pkg::REG_GRAM;
      val = pop_data.value;
      cnt = pop_data.count;
    end else begin
      case (wpos)
        3'd0: begin
          idx = lwfs_pkg::REG_WIN_XS;
          val = lwfs_pkg::COLOR_W'(pop_data.ax1);
        end
        3'd1: begin
          idx = lwfs_pkg::REG_WIN_XE;
          val = lwfs_pkg::COLOR_W'(pop_data.ax2);
        end
        3'd2: begin
          idx = lwfs_pkg::REG_WIN_YS;
          val = lwfs_pkg::COLOR_W'(pop_data.ay1);
        end
        3'd3: begin
          idx = lwfs_pkg::REG_WIN_YE;
          val = lwfs_pkg::COLOR_W'(pop_data.ay2);
        end
        3'd4: begin
          idx = lwfs_pkg::REG_ADDR_X;
          val = lwfs_pkg::COLOR_W'(pop_data.cx);
        end
        default: begin
          idx = lwfs_pkg::REG_ADDR_Y;
          val = lwfs_pkg::COLOR_W'(pop_data.cy);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step          <= 3'd0;
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= pop_valid;
      if (pop_valid) begin
        step <= (step == lwfs_pkg::STEP_LAST) ? 3'd0 : step + 3'd1;
      end
    end
    if (out_free && pop_valid) begin
      out_idx      <= idx;
      out_val      <= val;
      out_cnt      <= cnt;
      m_axis_tlast <= (step == lwfs_pkg::STEP_LAST);
    end
  end

  assign m_axis_tdata = {7'd0, out_cnt, out_val, out_idx};

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step <= lwfs_pkg::STEP_LAST)
    else $error("write step ran past the last write");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |->
      (out_idx == lwfs_pkg::REG_GRAM || out_idx == lwfs_pkg::REG_ADDR_Y))
    else $error("closing beat is neither the GRAM write nor the address counter");

  a_count_gram: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && out_idx != lwfs_pkg::REG_GRAM |-> out_cnt == lwfs_pkg::COUNT_W'(1))
    else $error("repeat count above one outside a GRAM write");

  a_job_start: assert property (@(posedge clk) disable iff (rst)
    pop_valid && pop_ready |=> step == 3'd0)
    else $error("next job did not start at its first write");

endmodule
`default_nettype wire

// File: sv/lcd_window_fill_sequencer.sv
// Top level: drawing requests in, LCD controller register writes out.
// Path: a request passes the clip stage register, the job queue and the back end's output
//   register before its first write beat appears.
// Throughput: seven write beats per drawing or rotation request, one beat per cycle
//   while m_axis_tready is high; the back end's single output register sets that figure.
//   Input takes one beat per cycle while the four-entry job queue and the clip stage have room.
// Reset (rst, synchronous): rotation returns to 0, clip stage, queue and output empty.
`timescale 1ns / 1ps
`default_nettype none
module lcd_window_fill_sequencer #(
  parameter int PANEL_WIDTH  = 240,
  parameter int PANEL_HEIGHT = 320
) (
  input  wire                                clk,
  input  wire                                rst,
  // Rotation register write (quarter turns).
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [1:0]                         cfg_data,
  // Request stream.
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: pos_x[8:0], pos_y[17:9], span_w[26:18], span_h[35:27],
  //        fill_color[51:36], zero [55:52]
  input  wire  [lwfs_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // tuser: req_type[2:0]
  input  wire  [2:0]                         s_axis_tuser,
  // Register write stream.
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // tdata: reg_index[7:0], reg_value[23:8], repeat_count[40:24], zero [47:41]
  output logic [lwfs_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // tlast: last_write
  output logic                               m_axis_tlast
);

  // The rotation register is always ready; it is to be written only while idle, which the block does not enforce.
  assign cfg_ready = 1'b1;

  logic           push_valid, push_ready;
  lwfs_pkg::cmd_t push_data;
  logic           pop_valid, pop_ready;
  lwfs_pkg::cmd_t pop_data;

  // Front end: drop off-screen, zero-size and unknown requests, clip at the
  // right and bottom edges, then rotate into panel space and size the fill.
  lwfs_front #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_rotation  (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_data     (push_data)
  );

  // Decouple the two sides so the front keeps taking requests during a long
  // output stall.
  lwfs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back end: hold each job at the queue head and step through its seven writes;
  // the job retires on the beat that carries tlast.
  lwfs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_data      (pop_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
`default_nettype wire

// File: verif/tb_lcd_window_fill_sequencer.sv
// Self-checking testbench for the LCD window fill sequencer: requests in, register writes checked.
`timescale 1ns / 1ps
`default_nettype none
module tb_lcd_window_fill_sequencer;

  localparam int PANEL_W = 240;
  localparam int PANEL_H = 320;
  localparam int COUNT_SAT = 131071;
  localparam int SETTLE_CYCLES = 30;
  localparam int HOLD_CYCLES = 400;
  localparam int ITEMS_PER_PHASE = 100;

  // Entry-mode register values, one per quarter turn.
  localparam logic [15:0] ENTRY_ROT0 = 16'h1030;
  localparam logic [15:0] ENTRY_ROT1 = 16'h1028;
  localparam logic [15:0] ENTRY_ROT2 = 16'h1000;
  localparam logic [15:0] ENTRY_ROT3 = 16'h1018;

  // Request codes the block does not know; it drops them silently.
  localparam logic [2:0] REQ_UNKNOWN_LO = 3'd5;
  localparam logic [2:0] REQ_UNKNOWN_HI = 3'd7;

  typedef struct packed {
    logic [7:0]  index;
    logic [15:0] value;
    logic [16:0] count;
    logic        last;
  } reg_write_t;

  // Holds the register writes still owed by accepted requests, oldest first.
  class lcd_write_scoreboard;
    reg_write_t pending_writes[$];
    logic [1:0] rotation;
    int         errors;

    function new();
      rotation = 2'd0;
      errors = 0;
    endfunction

    function void set_rotation(logic [1:0] r);
      rotation = r;
    endfunction

    function int pending();
      return pending_writes.size();
    endfunction

    function void push_write(logic [7:0] idx, int val, int cnt, bit last);
      reg_write_t w;
      w.index = idx;
      w.value = val[15:0];
      w.count = cnt[16:0];
      w.last = last;
      pending_writes.push_back(w);
    endfunction

    // Map a logical rectangle into panel coordinates: window, then address counter.
    function void push_window(int x1, int y1, int x2, int y2, bit last);
      int ax1, ax2, ay1, ay2, cx, cy;
      case (rotation)
        2'd1: begin
          ax1 = PANEL_W - 1 - y2; ax2 = PANEL_W - 1 - y1;
          ay1 = x1;               ay2 = x2;
          cx = ax2; cy = ay1;
        end
        2'd2: begin
          ax1 = PANEL_W - 1 - x2; ax2 = PANEL_W - 1 - x1;
          ay1 = PANEL_H - 1 - y2; ay2 = PANEL_H - 1 - y1;
          cx = ax2; cy = ay2;
        end
        2'd3: begin
          ax1 = y1;               ax2 = y2;
          ay1 = PANEL_H - 1 - x2; ay2 = PANEL_H - 1 - x1;
          cx = ax1; cy = ay2;
        end
        default: begin
          ax1 = x1; ax2 = x2; ay1 = y1; ay2 = y2;
          cx = ax1; cy = ay1;
        end
      endcase
      push_write(lwfs_pkg::REG_WIN_XS, ax1, 1, 1'b0);
      push_write(lwfs_pkg::REG_WIN_XE, ax2, 1, 1'b0);
      push_write(lwfs_pkg::REG_WIN_YS, ay1, 1, 1'b0);
      push_write(lwfs_pkg::REG_WIN_YE, ay2, 1, 1'b0);
      push_write(lwfs_pkg::REG_ADDR_X, cx, 1, 1'b0);
      push_write(lwfs_pkg::REG_ADDR_Y, cy, 1, last);
    endfunction

    // Work out every write that one accepted request causes.
    function void note_request(logic [2:0] kind, lwfs_pkg::coord_t x, lwfs_pkg::coord_t y,
                               lwfs_pkg::coord_t sw, lwfs_pkg::coord_t sh,
                               logic [15:0] color);
      int lw, lh, w, h, cnt;
      logic [15:0] entry;
      lw = rotation[0] ? PANEL_H : PANEL_W;
      lh = rotation[0] ? PANEL_W : PANEL_H;
      if (kind > lwfs_pkg::REQ_ROTATE) return;
      if (kind == lwfs_pkg::REQ_ROTATE) begin
        case (rotation)
          2'd1:    entry = ENTRY_ROT1;
          2'd2:    entry = ENTRY_ROT2;
          2'd3:    entry = ENTRY_ROT3;
          default: entry = ENTRY_ROT0;
        endcase
        push_write(lwfs_pkg::REG_ENTRY_MODE, entry, 1, 1'b0);
        push_window(0, 0, lw - 1, lh - 1, 1'b1);
        return;
      end
      if (int'(x) >= lw || int'(y) >= lh) return;
      w = int'(sw);
      h = int'(sh);
      case (kind)
        lwfs_pkg::REQ_PIXEL: begin w = 1; h = 1; end
        lwfs_pkg::REQ_HLINE: h = 1;
        lwfs_pkg::REQ_VLINE: w = 1;
        default: ;
      endcase
      if (w == 0 || h == 0) return;
      // Cut overhang at the right and bottom edges.
      if (w > lw - int'(x)) w = lw - int'(x);
      if (h > lh - int'(y)) h = lh - int'(y);
      push_window(int'(x), int'(y), int'(x) + w - 1, int'(y) + h - 1, 1'b0);
      cnt = w * h;
      if (cnt > COUNT_SAT) cnt = COUNT_SAT;
      push_write(lwfs_pkg::REG_GRAM, int'(color), cnt, 1'b1);
    endfunction

    function void check_write(logic [lwfs_pkg::OUT_TDATA_W-1:0] tdata, logic tlast);
      reg_write_t exp_w;
      if (pending_writes.size() == 0) begin
        $error("unexpected write beat: tdata=%h tlast=%b", tdata, tlast);
        errors++;
        return;
      end
      exp_w = pending_writes.pop_front();
      if (tdata[7:0] !== exp_w.index) begin
        $error("reg_index: expected %h, actual %h", exp_w.index, tdata[7:0]);
        errors++;
      end
      if (tdata[23:8] !== exp_w.value) begin
        $error("reg_value: expected %h, actual %h", exp_w.value, tdata[23:8]);
        errors++;
      end
      if (tdata[40:24] !== exp_w.count) begin
        $error("repeat_count: expected %0d, actual %0d", exp_w.count, tdata[40:24]);
        errors++;
      end
      if (tlast !== exp_w.last) begin
        $error("last_write: expected %b, actual %b", exp_w.last, tlast);
        errors++;
      end
      if (tdata[47:41] !== 7'd0) begin
        $error("tdata pad: expected 0, actual %h", tdata[47:41]);
        errors++;
      end
    endfunction
  endclass

  logic                             clk;
  logic                             rst;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [1:0]                       cfg_data;
  logic                             s_axis_tvalid;
  logic                             s_axis_tready;
  logic [lwfs_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
  logic [2:0]                       s_axis_tuser;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready;
  logic [lwfs_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                             m_axis_tlast;

  lcd_write_scoreboard sb;

  // Idling controls shared between the driving processes.
  bit         tx_idle_on;
  bit         rx_idle_on;
  int         hold_token;
  int         hold_seen;
  int         rx_hold_left;
  int         rx_idle_left;
  logic [1:0] cur_rot;

  lcd_window_fill_sequencer #(
    .PANEL_WIDTH  (PANEL_W),
    .PANEL_HEIGHT (PANEL_H)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Generous fixed limit; a stuck handshake ends the run here.
  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  // Receiver: check each accepted write beat, then choose next cycle's tready.
  // A long hold fills the job queue so that the input side stalls.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_idle_left = 0;
      rx_hold_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) sb.check_write(m_axis_tdata, m_axis_tlast);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        rx_hold_left = HOLD_CYCLES;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        m_axis_tready <= 1'b0;
      end else if (rx_idle_left > 0) begin
        rx_idle_left--;
        m_axis_tready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        rx_idle_left = $urandom_range(1, 11) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Offer one request beat and hold it until accepted; an optional gap goes first.
  task automatic send_request(logic [2:0] kind, lwfs_pkg::coord_t x, lwfs_pkg::coord_t y,
                              lwfs_pkg::coord_t w, lwfs_pkg::coord_t h,
                              logic [15:0] color);
    int gap;
    gap = (tx_idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 11) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {4'b0, color, h, w, y, x};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_request(kind, x, y, w, h, color);
  endtask

  // Random request: mostly on-screen drawing with edge bias, some rotation, some noise.
  task automatic send_random_request();
    logic [2:0]       kind;
    lwfs_pkg::coord_t x, y, w, h;
    logic [15:0]      color;
    int               lw, lh, pick, shape;
    lw = cur_rot[0] ? PANEL_H : PANEL_W;
    lh = cur_rot[0] ? PANEL_W : PANEL_H;
    pick = $urandom_range(0, 99);
    color = 16'($urandom);
    x = lwfs_pkg::coord_t'($urandom);
    y = lwfs_pkg::coord_t'($urandom);
    w = lwfs_pkg::coord_t'($urandom);
    h = lwfs_pkg::coord_t'($urandom);
    if (pick < 6) begin
      kind = lwfs_pkg::REQ_ROTATE;
    end else if (pick < 88) begin
      kind = 3'($urandom_range(lwfs_pkg::REQ_PIXEL, lwfs_pkg::REQ_RECT));
      x = ($urandom_range(0, 4) == 0) ? lwfs_pkg::coord_t'(lw - 1 - $urandom_range(0, 7))
                                      : lwfs_pkg::coord_t'($urandom_range(0, lw - 1));
      y = ($urandom_range(0, 4) == 0) ? lwfs_pkg::coord_t'(lh - 1 - $urandom_range(0, 7))
                                      : lwfs_pkg::coord_t'($urandom_range(0, lh - 1));
      shape = $urandom_range(0, 9);
      if (shape == 0) begin
        w = lwfs_pkg::coord_t'($urandom);
        h = lwfs_pkg::coord_t'($urandom);
      end else if (shape == 1) begin
        if ($urandom_range(0, 1)) w = '0;
        else h = '0;
      end else begin
        w = lwfs_pkg::coord_t'($urandom_range(1, 40));
        h = lwfs_pkg::coord_t'($urandom_range(1, 40));
      end
    end else begin
      kind = 3'($urandom);
    end
    send_request(kind, x, y, w, h, color);
  endtask

  // Drain, let any dropped request clear the pipeline, then write rotation.
  task automatic write_rotation(logic [1:0] r);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= r;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_rotation(r);
    cur_rot = r;
  endtask

  task automatic run_phase(logic [1:0] r, int count, bit pressure);
    write_rotation(r);
    send_request(lwfs_pkg::REQ_ROTATE, '0, '0, '0, '0, '0);
    for (int i = 0; i < count; i++) begin
      // Hold the receiver off and push request beats back to back into the block.
      if (pressure && i == 10) begin
        tx_idle_on = 1'b0;
        hold_token++;
      end
      if (pressure && i == 50) tx_idle_on = 1'b1;
      send_random_request();
    end
    // Drop the last beat so it is not taken twice.
    s_axis_tvalid <= 1'b0;
  endtask

  initial begin
    sb = new();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    hold_token = 0;
    hold_seen = 0;
    cur_rot = 2'd0;
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_data <= 2'd0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= lwfs_pkg::REQ_PIXEL;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at reset rotation: corners, off-screen, zero size, overhang, unknown kinds.
    send_request(lwfs_pkg::REQ_PIXEL, 9'd0, 9'd0, 9'd0, 9'd0, 16'h0000);
    send_request(lwfs_pkg::REQ_PIXEL, 9'd239, 9'd319, 9'd511, 9'd511, 16'hFFFF);
    send_request(lwfs_pkg::REQ_PIXEL, 9'd240, 9'd0, 9'd1, 9'd1, 16'h1234);
    send_request(lwfs_pkg::REQ_PIXEL, 9'd0, 9'd320, 9'd1, 9'd1, 16'h4321);
    send_request(lwfs_pkg::REQ_PIXEL, 9'd511, 9'd511, 9'd511, 9'd511, 16'hFFFF);
    send_request(lwfs_pkg::REQ_HLINE, 9'd10, 9'd20, 9'd0, 9'd7, 16'hF800);
    send_request(lwfs_pkg::REQ_HLINE, 9'd10, 9'd20, 9'd511, 9'd0, 16'h07E0);
    send_request(lwfs_pkg::REQ_VLINE, 9'd5, 9'd5, 9'd0, 9'd511, 16'h001F);
    send_request(lwfs_pkg::REQ_VLINE, 9'd5, 9'd5, 9'd9, 9'd0, 16'hAAAA);
    send_request(lwfs_pkg::REQ_RECT, 9'd0, 9'd0, 9'd240, 9'd320, 16'h5555);
    send_request(lwfs_pkg::REQ_RECT, 9'd0, 9'd0, 9'd511, 9'd511, 16'hFFFF);
    send_request(lwfs_pkg::REQ_RECT, 9'd100, 9'd200, 9'd0, 9'd5, 16'h0F0F);
    send_request(lwfs_pkg::REQ_RECT, 9'd100, 9'd200, 9'd5, 9'd0, 16'hF0F0);
    send_request(lwfs_pkg::REQ_RECT, 9'd239, 9'd319, 9'd1, 9'd1, 16'h8001);
    send_request(lwfs_pkg::REQ_RECT, 9'd17, 9'd33, 9'd31, 9'd47, 16'h5A5A);
    send_request(lwfs_pkg::REQ_RECT, 9'd200, 9'd300, 9'd100, 9'd100, 16'hA5A5);
    send_request(lwfs_pkg::REQ_ROTATE, 9'd511, 9'd511, 9'd511, 9'd511, 16'hFFFF);
    send_request(REQ_UNKNOWN_LO, 9'd1, 9'd1, 9'd1, 9'd1, 16'h1111);
    send_request(REQ_UNKNOWN_LO + 3'd1, 9'd511, 9'd511, 9'd511, 9'd511, 16'hFFFF);
    send_request(REQ_UNKNOWN_HI, 9'd0, 9'd0, 9'd0, 9'd0, 16'h0000);
    send_request(lwfs_pkg::REQ_PIXEL, 9'd3, 9'd4, 9'd0, 9'd0, 16'hBEEF);
    s_axis_tvalid <= 1'b0;

    // Random phases across all rotations, extremes included; the last runs without idling.
    run_phase(2'd3, ITEMS_PER_PHASE, 1'b0);
    run_phase(2'd1, ITEMS_PER_PHASE, 1'b1);
    run_phase(2'd2, ITEMS_PER_PHASE, 1'b0);
    run_phase(2'd0, ITEMS_PER_PHASE, 1'b0);
    while (sb.pending() != 0) @(posedge clk);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_phase(2'd3, ITEMS_PER_PHASE, 1'b0);

    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
